@@ design/pfl_pkg.sv @@
// Package for the path feature locator: shared constants, codes and the
// structs that pass between the top level, the table unit and the divider.
// No dependencies.
package pfl_pkg;

	localparam int MAX_ARCS  = 254;
	localparam int SEG_DEPTH = MAX_ARCS + 2;
	localparam int ARC_DEPTH = MAX_ARCS + 1;

	localparam int BASE_W = 42;	// signed feature base, Q.16
	localparam int SCL_W  = 60;	// signed scaled position, Q.32
	localparam int NUM_W  = 58;	// divider numerator
	localparam int DEN_W  = 42;	// divider denominator
	localparam int FRAC_W = 17;

	localparam logic [FRAC_W-1:0] ONE_Q16 = 17'd65536;

	localparam logic [1:0] MODE_SEG   = 2'd0;
	localparam logic [1:0] MODE_ARC   = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	typedef struct packed {
		logic        seg_en;
		logic        arc_en;
		logic [7:0]  idx;
		logic [31:0] len;
		logic [31:0] ang;
	} mem_wr_t;

	typedef struct packed {
		logic       start;
		logic [8:0] index;
	} base_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [BASE_W-1:0] base;
	} base_rsp_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [FRAC_W-1:0] quot;
	} div_rsp_t;

endpackage

@@ design/pfl_item_if.sv @@
// Input channel of the path feature locator: valid/ready plus item payload.
// No dependencies.
interface pfl_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [7:0]         entry_index;
	logic signed [31:0] length_value;
	logic signed [31:0] angle_value;
	logic [16:0]        position_fraction;
	logic signed [31:0] lateral_offset;

	modport source (output valid, mode, entry_index, length_value, angle_value,
		position_fraction, lateral_offset, input ready);
	modport sink (input valid, mode, entry_index, length_value, angle_value,
		position_fraction, lateral_offset, output ready);
endinterface

@@ design/pfl_result_if.sv @@
// Output channel of the path feature locator: valid/ready plus result payload.
// No dependencies.
interface pfl_result_if;
	logic        valid;
	logic        ready;
	logic [8:0]  feature_index;
	logic        is_arc;
	logic [16:0] local_fraction;

	modport source (output valid, feature_index, is_arc, local_fraction, input ready);
	modport sink (input valid, feature_index, is_arc, local_fraction, output ready);
endinterface

@@ design/pfl_base_unit.sv @@
// Table memories and the three-stage feature base pipeline.
// Depends on pfl_pkg.
module pfl_base_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pfl_pkg::mem_wr_t     wr,
	input  pfl_pkg::base_req_t   req,
	input  logic signed [31:0]   offset,
	output pfl_pkg::base_rsp_t   rsp
);

	logic signed [31:0] seg_mem [0:pfl_pkg::SEG_DEPTH-1];
	logic [63:0]        arc_mem [0:pfl_pkg::ARC_DEPTH-1];

	logic [7:0] seg_addr;
	logic [7:0] arc_addr;

	logic               v_s1, v_s2, v_s3;
	logic               zero_s1, zero_s2;
	logic signed [31:0] seg_s1, seg_s2;
	logic [63:0]        arc_s1;
	logic signed [31:0] len_s2;
	logic signed [63:0] prod_s2;
	logic signed [pfl_pkg::BASE_W-1:0] base_s3;

	logic signed [63:0] rnd;
	logic signed [39:0] prod_r;
	logic signed [pfl_pkg::BASE_W-1:0] sum;

	assign arc_addr = req.index[8:1];
	assign seg_addr = req.index[8:1] + 8'(req.index[0]);

	always_ff @(posedge clk) begin
		if (wr.seg_en) begin
			seg_mem[wr.idx] <= wr.len;
		end
		if (wr.arc_en && (wr.idx < 8'(pfl_pkg::ARC_DEPTH))) begin
			arc_mem[wr.idx] <= {wr.len, wr.ang};
		end
		if (req.start) begin
			seg_s1 <= seg_mem[seg_addr];
			arc_s1 <= arc_mem[arc_addr];
		end
	end

	// Round the Q24.40 product to Q24.16, ties toward plus infinity.
	always_comb begin
		rnd    = prod_s2 + 64'sd8388608;
		prod_r = $signed(rnd[63:24]);
		sum    = {{10{seg_s2[31]}}, seg_s2} + {{10{len_s2[31]}}, len_s2}
			+ {{2{prod_r[39]}}, prod_r};
	end

	always_ff @(posedge clk) begin
		prod_s2 <= offset * $signed(arc_s1[31:0]);
		len_s2  <= $signed(arc_s1[63:32]);
		seg_s2  <= seg_s1;
		zero_s2 <= zero_s1;
		if (zero_s2) begin
			base_s3 <= {{10{seg_s2[31]}}, seg_s2};
		end else if (sum[pfl_pkg::BASE_W-1]) begin
			base_s3 <= '0;
		end else begin
			base_s3 <= sum;
		end
		if (req.start) begin
			zero_s1 <= (req.index == 9'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign rsp.done = v_s3;
	assign rsp.base = base_s3;

endmodule

@@ design/pfl_div.sv @@
// Restoring divider for the local fraction, one quotient bit per cycle,
// saturating at one. Depends on pfl_pkg.
module pfl_div (
	input  logic                clk,
	input  logic                arst_n,
	input  pfl_pkg::div_req_t   req,
	output pfl_pkg::div_rsp_t   rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [4:0]                    cnt_q;
	logic [pfl_pkg::NUM_W-1:0]     rem_q;
	logic [pfl_pkg::NUM_W-1:0]     dsh_q;
	logic [pfl_pkg::FRAC_W-1:0]    quot_q;
	logic [pfl_pkg::FRAC_W-1:0]    res_q;

	logic                          fits;
	logic [pfl_pkg::FRAC_W-1:0]    quot_nx;

	assign fits    = (rem_q >= dsh_q);
	assign quot_nx = {quot_q[pfl_pkg::FRAC_W-2:0], fits};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if ({1'b0, req.num} >= {req.den, 17'd0}) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= 5'd16;
				end
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.num;
			dsh_q  <= {req.den, 16'd0};
			quot_q <= '0;
			res_q  <= pfl_pkg::ONE_Q16;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q  <= dsh_q >> 1;
			quot_q <= quot_nx;
			if (cnt_q == 5'd0) begin
				res_q <= (quot_nx > pfl_pkg::ONE_Q16) ? pfl_pkg::ONE_Q16 : quot_nx;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = res_q;

endmodule

@@ design/path_feature_locator_unit.sv @@
// Top level of the path feature locator: control sequencer, configuration
// register and result register. Depends on pfl_pkg, pfl_item_if,
// pfl_result_if, pfl_base_unit and pfl_div.
//
// Usage. Items arrive on the item channel; a transfer takes place at a rising
// edge where valid and ready are both high. Mode 0 writes a cumulative segment
// length, mode 1 writes a cumulative arc length and angle pair, mode 2 is a
// locate query, and mode 3 is dropped. Writes complete on the transfer edge and
// give no result, so the next item may follow in the next cycle. A query gives
// exactly one transfer on the result channel: feature index, arc flag and the
// local fraction in Q1.16. The user must write the arc count register through
// cfg_wr_en and cfg_wr_data only while idle; the block does not enforce it.
// A query walks the tables through one read port per memory, and each feature
// base passes through read, multiply, and sum and clamp. A query runs the
// total length, the scaling, up to 9 search steps, the step back, the current
// base, the next base and one more base per skipped zero-size feature, then
// the serial divide and the finish step. The block works on one query at a
// time; the next item can be taken in the cycle after the result is
// registered.
// Reset clears the arc count, the sequencer and the result valid flag; table
// contents are undefined until written. When the receiver stalls, a finished
// result waits in the sequencer until the result register frees up; the item
// channel is not ready until then.
module path_feature_locator_unit (
	input  logic               clk,
	input  logic               arst_n,
	pfl_item_if.sink           item,
	pfl_result_if.source       result,
	input  logic               cfg_wr_en,
	input  logic [7:0]         cfg_wr_data
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_TOT   = 4'd1;
	localparam logic [3:0] S_TWAIT = 4'd2;
	localparam logic [3:0] S_MUL1  = 4'd3;
	localparam logic [3:0] S_MUL2  = 4'd4;
	localparam logic [3:0] S_SRCH  = 4'd5;
	localparam logic [3:0] S_SWAIT = 4'd6;
	localparam logic [3:0] S_CUR   = 4'd7;
	localparam logic [3:0] S_CWAIT = 4'd8;
	localparam logic [3:0] S_NXT   = 4'd9;
	localparam logic [3:0] S_NWAIT = 4'd10;
	localparam logic [3:0] S_DIV   = 4'd11;
	localparam logic [3:0] S_DWAIT = 4'd12;
	localparam logic [3:0] S_FIN   = 4'd13;

	logic [3:0]  state_q;
	logic [7:0]  arc_count_q;
	logic [8:0]  n2_q;
	logic [8:0]  lo_q, hi_q, mid_q;
	logic [16:0] t_q;
	logic signed [31:0] off_q;
	logic signed [pfl_pkg::BASE_W-1:0] total_q, bcur_q, bnxt_q;
	logic [40:0] plo_q;
	logic signed [pfl_pkg::SCL_W-1:0] scaled_q;
	logic [16:0] local_q;

	logic        out_valid_q;
	logic [8:0]  out_index_q;
	logic [16:0] out_frac_q;

	pfl_pkg::mem_wr_t   mem_wr;
	pfl_pkg::base_req_t base_req;
	pfl_pkg::base_rsp_t base_rsp;
	pfl_pkg::div_req_t  div_req;
	pfl_pkg::div_rsp_t  div_rsp;

	logic        accept;
	logic [7:0]  n_eff;
	logic [8:0]  mid_c;
	logic [33:0] phi;
	logic signed [pfl_pkg::SCL_W-1:0] base_scl;
	logic signed [pfl_pkg::SCL_W-1:0] num_c;
	logic signed [pfl_pkg::BASE_W:0]  size_c;
	logic        out_free;

	assign accept   = item.valid && item.ready;
	assign item.ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || result.ready;

	// Arc counts beyond the table act as the largest table.
	assign n_eff = (arc_count_q > 8'(pfl_pkg::MAX_ARCS)) ? 8'(pfl_pkg::MAX_ARCS)
		: arc_count_q;
	assign mid_c = 9'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign phi   = t_q * total_q[40:24];

	// Candidate feature base and divider numerator in Q.32, denominator in Q.16.
	assign base_scl = {{2{base_rsp.base[pfl_pkg::BASE_W-1]}}, base_rsp.base, 16'd0};
	assign num_c    = scaled_q - {{2{bcur_q[pfl_pkg::BASE_W-1]}}, bcur_q, 16'd0};
	assign size_c   = {bnxt_q[pfl_pkg::BASE_W-1], bnxt_q}
		- {bcur_q[pfl_pkg::BASE_W-1], bcur_q};

	always_comb begin
		mem_wr.seg_en = accept && (item.mode == pfl_pkg::MODE_SEG);
		mem_wr.arc_en = accept && (item.mode == pfl_pkg::MODE_ARC);
		mem_wr.idx    = item.entry_index;
		mem_wr.len    = item.length_value;
		mem_wr.ang    = item.angle_value;

		base_req.start = 1'b0;
		base_req.index = '0;
		unique case (state_q)
			S_TOT: begin
				base_req.start = 1'b1;
				base_req.index = n2_q + 9'd1;
			end
			S_SRCH: begin
				base_req.start = (lo_q < hi_q);
				base_req.index = mid_c;
			end
			S_CUR: begin
				base_req.start = 1'b1;
				base_req.index = lo_q;
			end
			S_NXT: begin
				base_req.start = 1'b1;
				base_req.index = lo_q + 9'd1;
			end
			default: begin
				base_req.start = 1'b0;
			end
		endcase

		div_req.start = (state_q == S_DIV) && !size_c[pfl_pkg::BASE_W] && (size_c != '0)
			&& !num_c[pfl_pkg::SCL_W-1] && (num_c != '0);
		div_req.num   = num_c[pfl_pkg::NUM_W-1:0];
		div_req.den   = size_c[pfl_pkg::DEN_W-1:0];
	end

	pfl_base_unit u_base (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (mem_wr),
		.req    (base_req),
		.offset (off_q),
		.rsp    (base_rsp)
	);

	pfl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer: total length, scaling, binary search, step back, zero-size
	// skip, then the divide for the local fraction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			arc_count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				arc_count_q <= cfg_wr_data;
			end
			// A finished query refills the result register in the same cycle
			// that the receiver takes the previous result.
			if ((state_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && (item.mode == pfl_pkg::MODE_QUERY)) begin
						state_q <= S_TOT;
					end
				end
				S_TOT:   state_q <= S_TWAIT;
				S_TWAIT: if (base_rsp.done) begin
					state_q <= S_MUL1;
				end
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_SRCH;
				S_SRCH:  state_q <= (lo_q < hi_q) ? S_SWAIT : S_CUR;
				S_SWAIT: if (base_rsp.done) begin
					state_q <= S_SRCH;
				end
				S_CUR:   state_q <= S_CWAIT;
				S_CWAIT: if (base_rsp.done) begin
					state_q <= S_NXT;
				end
				S_NXT:   state_q <= S_NWAIT;
				S_NWAIT: if (base_rsp.done) begin
					state_q <= ((lo_q < n2_q) && (base_rsp.base == bcur_q)) ? S_NXT : S_DIV;
				end
				S_DIV:   state_q <= div_req.start ? S_DWAIT : S_FIN;
				S_DWAIT: if (div_rsp.done) begin
					state_q <= S_FIN;
				end
				S_FIN: if (out_free) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				t_q   <= (item.position_fraction > pfl_pkg::ONE_Q16) ? pfl_pkg::ONE_Q16
					: item.position_fraction;
				off_q <= item.lateral_offset;
				n2_q  <= {n_eff, 1'b0};
				lo_q  <= '0;
				hi_q  <= {n_eff, 1'b1};
			end
			S_TWAIT: if (base_rsp.done) begin
				total_q <= base_rsp.base;
			end
			S_MUL1: plo_q <= t_q * total_q[23:0];
			S_MUL2: scaled_q <= $signed(60'(plo_q) + (60'(phi) << 24));
			S_SRCH: begin
				mid_q <= mid_c;
				if (!(lo_q < hi_q) && (lo_q != 9'd0)) begin
					lo_q <= lo_q - 9'd1;
				end
			end
			S_SWAIT: if (base_rsp.done) begin
				if (base_scl < scaled_q) begin
					lo_q <= mid_q + 9'd1;
				end else begin
					hi_q <= mid_q;
				end
			end
			S_CWAIT: if (base_rsp.done) begin
				bcur_q <= base_rsp.base;
			end
			S_NWAIT: if (base_rsp.done) begin
				if ((lo_q < n2_q) && (base_rsp.base == bcur_q)) begin
					lo_q   <= lo_q + 9'd1;
					bcur_q <= base_rsp.base;
				end else begin
					bnxt_q <= base_rsp.base;
				end
			end
			S_DIV: local_q <= '0;
			S_DWAIT: if (div_rsp.done) begin
				local_q <= div_rsp.quot;
			end
			S_FIN: if (out_free) begin
				out_index_q <= lo_q;
				out_frac_q  <= local_q;
			end
			default: begin
			end
		endcase
	end

	assign result.valid          = out_valid_q;
	assign result.feature_index  = out_index_q;
	assign result.is_arc         = out_index_q[0];
	assign result.local_fraction = out_frac_q;

	// A result appears only when the sequencer finishes a query.
	a_rise_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q) == S_FIN)
		else $error("result raised outside the finish step");

	// No base lookup is in flight once the sequencer is back to idle.
	a_idle_no_base: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !base_rsp.done)
		else $error("base lookup completed while idle");

	// The divider only reports back while the sequencer waits for it.
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DWAIT)
		else $error("divider done outside its wait step");

	// The local fraction never exceeds one.
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.local_fraction <= pfl_pkg::ONE_Q16)
		else $error("local fraction above one");

endmodule
